// ===== hw/rtl/msi_pkg.sv =====
package msi_pkg;

    // Defaults for the top-level parameters.
    localparam int ADDR_WIDTH_DEF = 12;
    localparam int NUM_PROCS_DEF  = 3;

    // Fixed field widths of the access and result words.
    localparam int PROC_W       = 2;
    localparam int ADDR_FIELD_W = 12;
    localparam int KIND_W       = 2;
    localparam int MASK_W       = 3;
    localparam int SHIFT_W      = 3;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd2;

    // Per-processor line state codes as stored in the state RAM.
    localparam logic [1:0] ST_I = 2'd0;
    localparam logic [1:0] ST_M = 2'd1;
    localparam logic [1:0] ST_S = 2'd2;

    // Access opcodes.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Access kind codes reported with each result.
    localparam logic [KIND_W-1:0] KIND_RD_HIT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RD_MISS = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WR_HIT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_WR_MISS = 2'd3;

    typedef enum logic [1:0] {
        CTRL_CLEAR,
        CTRL_IDLE,
        CTRL_LOOKUP
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_wr;
        logic capture;
        logic update;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic proc_ok;
    } dp_status_t;

endpackage

// ===== hw/rtl/msi_ram.sv =====
module msi_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/msi_ctrl.sv =====
module msi_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  msi_pkg::dp_status_t   status,
    output msi_pkg::ctrl_cmd_t    cmd,
    output logic                  busy
);

    msi_pkg::ctrl_state_t state_reg;
    msi_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msi_pkg::CTRL_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.clr_wr  = 1'b0;
        cmd.capture = 1'b0;
        cmd.update  = 1'b0;
        busy        = 1'b1;
        case (state_reg)
            msi_pkg::CTRL_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last)
                begin
                    state_next = msi_pkg::CTRL_IDLE;
                end
            end
            msi_pkg::CTRL_IDLE:
            begin
                busy = 1'b0;
                // An access from a nonexistent processor is taken and dropped.
                if (start && status.proc_ok)
                begin
                    cmd.capture = 1'b1;
                    state_next  = msi_pkg::CTRL_LOOKUP;
                end
            end
            msi_pkg::CTRL_LOOKUP:
            begin
                cmd.update = 1'b1;
                state_next = msi_pkg::CTRL_IDLE;
            end
            default:
            begin
                state_next = msi_pkg::CTRL_CLEAR;
            end
        endcase
    end

endmodule

// ===== hw/rtl/msi_dpath.sv =====
module msi_dpath #(
    parameter int ADDR_WIDTH = msi_pkg::ADDR_WIDTH_DEF,
    parameter int NUM_PROCS  = msi_pkg::NUM_PROCS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  msi_pkg::ctrl_cmd_t               cmd,
    output msi_pkg::dp_status_t              status,
    input  logic [msi_pkg::PROC_W-1:0]       proc_id,
    input  logic                             opcode,
    input  logic [msi_pkg::ADDR_FIELD_W-1:0] address,
    input  logic                             cfg_we,
    input  logic [msi_pkg::SHIFT_W-1:0]      cfg_data,
    output logic                             done,
    output logic [msi_pkg::KIND_W-1:0]       access_kind,
    output logic                             broadcast_inval,
    output logic [msi_pkg::MASK_W-1:0]       writeback_mask,
    output logic [msi_pkg::MASK_W-1:0]       invalidate_mask
);

    localparam int EntryW = 2 * NUM_PROCS;
    localparam int Depth  = 1 << ADDR_WIDTH;
    localparam int WideW  = ADDR_WIDTH + msi_pkg::ADDR_FIELD_W;

    function automatic logic [1:0] st_decode(input logic [1:0] code);
        // The unused code reads as Invalid.
        return (code == 2'd3) ? msi_pkg::ST_I : code;
    endfunction

    logic [msi_pkg::SHIFT_W-1:0]  block_shift_reg;
    logic [ADDR_WIDTH-1:0]        clr_cnt_reg;
    logic                         done_reg;

    logic [msi_pkg::PROC_W-1:0]   proc_reg;
    logic                         op_reg;
    logic [ADDR_WIDTH-1:0]        idx_reg;
    logic [msi_pkg::KIND_W-1:0]   kind_reg;
    logic                         bcast_reg;
    logic [msi_pkg::MASK_W-1:0]   wb_reg;
    logic [msi_pkg::MASK_W-1:0]   inv_reg;

    logic [WideW-1:0]             addr_wide;
    logic [ADDR_WIDTH-1:0]        addr_ext;
    logic [ADDR_WIDTH-1:0]        idx;

    logic [EntryW-1:0]            rd_data;
    logic [EntryW-1:0]            entry_next;
    logic [1:0]                   own;
    logic [1:0]                   other;
    logic [msi_pkg::KIND_W-1:0]   kind;
    logic                         bcast;
    logic [msi_pkg::MASK_W-1:0]   wb;
    logic [msi_pkg::MASK_W-1:0]   inv;

    logic                         ram_we;
    logic [ADDR_WIDTH-1:0]        ram_waddr;
    logic [EntryW-1:0]            ram_wdata;

    // Only the low ADDR_WIDTH bits of the byte address take part.
    assign addr_wide = {{ADDR_WIDTH{1'b0}}, address};
    assign addr_ext  = addr_wide[ADDR_WIDTH-1:0];
    assign idx       = addr_ext >> block_shift_reg;

    assign status.proc_ok  = ({1'b0, proc_id} < (msi_pkg::PROC_W + 1)'(NUM_PROCS));
    assign status.clr_last = &clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_shift_reg <= msi_pkg::SHIFT_RESET;
            clr_cnt_reg     <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                block_shift_reg <= cfg_data;
            end
            if (cmd.clr_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            done_reg <= cmd.update;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            proc_reg <= proc_id;
            op_reg   <= opcode;
            idx_reg  <= idx;
        end
        if (cmd.update)
        begin
            kind_reg  <= kind;
            bcast_reg <= bcast;
            wb_reg    <= wb;
            inv_reg   <= inv;
        end
    end

    // Snoop update: on a read miss or non-M write all other copies are examined in parallel.
    always_comb
    begin
        entry_next = rd_data;
        kind       = msi_pkg::KIND_RD_HIT;
        bcast      = 1'b0;
        wb         = '0;
        inv        = '0;
        own        = msi_pkg::ST_I;
        other      = msi_pkg::ST_I;
        for (int p = 0; p < NUM_PROCS; p++)
        begin
            if (2'(p) == proc_reg)
            begin
                own = st_decode(rd_data[2*p +: 2]);
            end
        end
        if (op_reg == msi_pkg::OP_READ)
        begin
            if (own != msi_pkg::ST_I)
            begin
                kind = msi_pkg::KIND_RD_HIT;
            end
            else
            begin
                kind = msi_pkg::KIND_RD_MISS;
                for (int p = 0; p < NUM_PROCS; p++)
                begin
                    other = st_decode(rd_data[2*p +: 2]);
                    if (2'(p) == proc_reg)
                    begin
                        entry_next[2*p +: 2] = msi_pkg::ST_S;
                    end
                    else if (other == msi_pkg::ST_M)
                    begin
                        wb[p]                = 1'b1;
                        entry_next[2*p +: 2] = msi_pkg::ST_S;
                    end
                end
            end
        end
        else if (own == msi_pkg::ST_M)
        begin
            kind = msi_pkg::KIND_WR_HIT;
        end
        else
        begin
            kind  = (own == msi_pkg::ST_S) ? msi_pkg::KIND_WR_HIT : msi_pkg::KIND_WR_MISS;
            bcast = 1'b1;
            for (int p = 0; p < NUM_PROCS; p++)
            begin
                other = st_decode(rd_data[2*p +: 2]);
                if (2'(p) == proc_reg)
                begin
                    entry_next[2*p +: 2] = msi_pkg::ST_M;
                end
                else
                begin
                    if (other == msi_pkg::ST_M)
                    begin
                        wb[p] = 1'b1;
                    end
                    if (other != msi_pkg::ST_I)
                    begin
                        inv[p]               = 1'b1;
                        entry_next[2*p +: 2] = msi_pkg::ST_I;
                    end
                end
            end
        end
    end

    assign ram_we    = cmd.clr_wr | cmd.update;
    assign ram_waddr = cmd.clr_wr ? clr_cnt_reg : idx_reg;
    assign ram_wdata = cmd.clr_wr ? '0 : entry_next;

    msi_ram #(
        .WIDTH (EntryW),
        .DEPTH (Depth)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (cmd.capture),
        .rd_addr (idx),
        .rd_data (rd_data)
    );

    assign done            = done_reg;
    assign access_kind     = kind_reg;
    assign broadcast_inval = bcast_reg;
    assign writeback_mask  = wb_reg;
    assign invalidate_mask = inv_reg;

endmodule

// ===== hw/rtl/msi_snoop_coherence.sv =====
// Three-processor snooping MSI coherence tracker. Each word on the access side
// names a processor, a read or write opcode and a byte address; it is taken at a
// rising edge where start is high and busy is low. Every access from an existing
// processor yields exactly one result word, registered after the LOOKUP state
// and shown for a single cycle with done high; the receiver cannot stall, so it
// must take the result in that cycle. Accesses from a processor number at or
// above NUM_PROCS are taken and dropped without a result. The block takes no
// new access until the last one has passed the LOOKUP state, in which busy is
// high and the read-modify-write of the line state RAM completes: the line is
// read in the accept cycle and written back, with the result registered, in the
// next. After reset the block sweeps the state RAM to all-Invalid, one entry
// per cycle, with busy high; block_shift writes are taken at any time, also
// during that sweep, but should only be issued while no access is in flight.
module msi_snoop_coherence #(
    parameter int ADDR_WIDTH = msi_pkg::ADDR_WIDTH_DEF,
    parameter int NUM_PROCS  = msi_pkg::NUM_PROCS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    // Access command channel.
    input  logic                             start,
    output logic                             busy,
    input  logic [msi_pkg::PROC_W-1:0]       proc_id,
    input  logic                             opcode,
    input  logic [msi_pkg::ADDR_FIELD_W-1:0] address,

    // Result channel: one word per cycle of done, no back-pressure.
    output logic                             done,
    output logic [msi_pkg::KIND_W-1:0]       access_kind,
    output logic                             broadcast_inval,
    output logic [msi_pkg::MASK_W-1:0]       writeback_mask,
    output logic [msi_pkg::MASK_W-1:0]       invalidate_mask,

    // Configuration channel for block_shift.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [msi_pkg::SHIFT_W-1:0]      cfg_data
);

    msi_pkg::ctrl_cmd_t  cmd;
    msi_pkg::dp_status_t status;

    // The shift register accepts a write in every cycle.
    assign cfg_ready = 1'b1;

    // The controller sequences the clearing sweep and the read-modify-write
    // of each access.
    msi_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // The datapath holds the state RAM, the block shift and the result registers.
    msi_dpath #(
        .ADDR_WIDTH (ADDR_WIDTH),
        .NUM_PROCS  (NUM_PROCS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .proc_id         (proc_id),
        .opcode          (opcode),
        .address         (address),
        .cfg_we          (cfg_valid & cfg_ready),
        .cfg_data        (cfg_data),
        .done            (done),
        .access_kind     (access_kind),
        .broadcast_inval (broadcast_inval),
        .writeback_mask  (writeback_mask),
        .invalidate_mask (invalidate_mask)
    );

endmodule

// ===== hw/rtl/msi_checker.sv =====
module msi_checker #(
    parameter int NUM_PROCS = msi_pkg::NUM_PROCS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic [msi_pkg::PROC_W-1:0] proc_id,
    input  logic                       done,
    input  logic [msi_pkg::KIND_W-1:0] access_kind,
    input  logic                       broadcast_inval,
    input  logic [msi_pkg::MASK_W-1:0] invalidate_mask
);

    // Every access from an existing processor is answered with a result.
    a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ({1'b0, proc_id} < (msi_pkg::PROC_W + 1)'(NUM_PROCS)))
        |-> ##2 done)
        else $error("access not answered two cycles after acceptance");

    // A result follows a busy cycle and frees the command side.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result shown outside the lookup sequence");

    // Results are single-cycle strobes.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // Reads never broadcast or invalidate other copies.
    a_read_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (access_kind == msi_pkg::KIND_RD_HIT ||
                  access_kind == msi_pkg::KIND_RD_MISS))
        |-> (!broadcast_inval && invalidate_mask == '0))
        else $error("read reported invalidations");

    // A write miss always broadcasts invalidations.
    a_write_miss_bcast: assert property (@(posedge clk) disable iff (!rst_n)
        (done && access_kind == msi_pkg::KIND_WR_MISS) |-> broadcast_inval)
        else $error("write miss without broadcast");

endmodule

bind msi_snoop_coherence msi_checker #(
    .NUM_PROCS (NUM_PROCS)
) u_msi_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .proc_id         (proc_id),
    .done            (done),
    .access_kind     (access_kind),
    .broadcast_inval (broadcast_inval),
    .invalidate_mask (invalidate_mask)
);
